>>> hdl/ctfl_pkg.sv
// ----------------------------------------------------------------------------
// ctfl_pkg
// Shared types and codes for the connection table with linked free list.
// ----------------------------------------------------------------------------
package ctfl_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned CFG_W  = 7;

  // operations
  localparam logic [OP_W-1:0] OP_REGISTER  = 3'd0;
  localparam logic [OP_W-1:0] OP_END_OP    = 3'd1;
  localparam logic [OP_W-1:0] OP_CHECK     = 3'd2;
  localparam logic [OP_W-1:0] OP_UNREG     = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAN     = 3'd4;
  // unassigned operation codes, first and last
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  // result codes
  localparam logic [CODE_W-1:0] RC_OK        = 3'd0;
  localparam logic [CODE_W-1:0] RC_FULL      = 3'd1;
  localparam logic [CODE_W-1:0] RC_RANGE     = 3'd2;
  localparam logic [CODE_W-1:0] RC_NOT_READY = 3'd3;
  localparam logic [CODE_W-1:0] RC_NOTHING   = 3'd4;
  localparam logic [CODE_W-1:0] RC_NO_MATCH  = 3'd5;

  // entry states
  localparam logic [1:0] ST_EMPTY  = 2'd0;
  localparam logic [1:0] ST_ACTIVE = 2'd1;
  localparam logic [1:0] ST_SYNC   = 2'd2;
  localparam logic [1:0] ST_STALE  = 2'd3;

  typedef struct packed {
    logic [7:0]  thread;
    logic [15:0] socket;
    logic [31:0] address;
    logic [15:0] port;
    logic [31:0] stamp;
    logic [31:0] last_stamp;
    logic [31:0] ops;
  } entry_rec_t;

endpackage

>>> hdl/connection_table_free_list_top.sv
// ----------------------------------------------------------------------------
// connection_table_free_list_top
// Connection table with a linked free list, one shared record memory port.
// ----------------------------------------------------------------------------
// Usage: drive an operation on the in_ ports and pulse start while busy is
// low; the word is taken at that edge. busy stays high while the sequencer
// works. The result word is loaded into the out_ ports and marked by out_strobe,
// high for a single cycle, as busy falls; the receiver cannot stall it.
// From accept: register passes decode and S_LINK; ending operation, check
// obsolete and unregister pass decode and S_RMW; a full table, out-of-range
// index or unknown operation ends in decode; clean scans all n_r entries,
// one record per cycle through the single read port of the record memory.
// A new word may be started in the strobe cycle.
// cfg_ready equals !busy. A cfg write clamps the count to 1..MAX_ENTRIES,
// marks every entry empty and restarts the free list.
// Reset (rst_n low, synchronous) gives MAX_ENTRIES entries, all empty.
// Record memory has no clear: an empty entry always reads as zeros.
// State memory is trusted only below the fresh pointer, so no clearing pass.
// ----------------------------------------------------------------------------
module connection_table_free_list_top
  import ctfl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [7:0]          in_worker_thread,
  input  logic [15:0]         in_socket_handle,
  input  logic [31:0]         in_peer_address,
  input  logic [15:0]         in_peer_port,
  input  logic [31:0]         in_now_seconds,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                out_strobe,
  output logic [CODE_W-1:0]   out_result_code,
  output logic [IDX_W-1:0]    out_result_index,
  output logic [7:0]          out_result_thread,
  output logic [15:0]         out_result_socket,
  output logic [31:0]         out_result_address,
  output logic [15:0]         out_result_port,
  output logic [31:0]         out_result_entry_time,
  output logic [31:0]         out_result_last_time,
  output logic [31:0]         out_result_op_count
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_RMW  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;

  logic [2:0]       seq_r, seq_nxt;
  logic [CW-1:0]    n_r;
  logic [CW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;

  // latched command word
  logic [OP_W-1:0]  op_r;
  logic [IDX_W-1:0] idx_r;
  entry_rec_t       cmd_r;

  // record, state and link memories
  entry_rec_t       rec_mem [MAX_ENTRIES];
  logic [1:0]       st_mem [MAX_ENTRIES];
  logic [CW-1:0]    link_mem [MAX_ENTRIES];
  entry_rec_t       rec_q;
  logic [1:0]       st_q;
  logic [IW-1:0]    rd_idx_r;
  logic [CW-1:0]    link_q;
  logic [IW-1:0]    rd_addr;
  logic             rec_we;
  logic [IW-1:0]    rec_wa;
  entry_rec_t       rec_wd;
  logic             link_we;

  logic             st_we;
  logic [IW-1:0]    st_wa;
  logic [1:0]       st_wd;

  // clean scan
  logic [CW-1:0]    scan_r, scan_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]    cmp_idx_r;
  logic             found_r, found_nxt;
  logic [IW-1:0]    last_r, last_nxt;
  logic [7:0]       thr_r, thr_nxt;

  logic             res_ld;
  logic [CODE_W-1:0] res_code;
  logic [IDX_W-1:0] res_idx;
  entry_rec_t       res_rec;

  logic             accept, rebuild;
  logic             idx_oob, head_full;
  logic [IW-1:0]    idx_w, head_w;
  logic [1:0]       cur_st;
  entry_rec_t       cur_rec;
  logic [CW-1:0]    cfg_clamped;

  assign busy      = (seq_r != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign rebuild   = cfg_valid && cfg_ready;

  assign idx_w     = idx_r[IW-1:0];
  assign head_w    = head_r[IW-1:0];
  assign idx_oob   = (32'(idx_r) >= 32'(n_r));
  assign head_full = (head_r >= n_r);
  // entries at or above the fresh pointer were never taken since the rebuild
  assign cur_st    = (CW'(rd_idx_r) < fill_r) ? st_q : ST_EMPTY;
  assign cur_rec   = (cur_st == ST_EMPTY) ? '0 : rec_q;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CW'(1);
    end else if (32'(cfg_data) > MAX_ENTRIES) begin
      cfg_clamped = CW'(MAX_ENTRIES);
    end else begin
      cfg_clamped = CW'(cfg_data);
    end
  end

  always_comb begin
    seq_nxt   = seq_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    scan_nxt  = scan_r;
    cmp_v_nxt = 1'b0;
    found_nxt = found_r;
    last_nxt  = last_r;
    thr_nxt   = thr_r;
    rd_addr   = idx_w;
    rec_we    = 1'b0;
    rec_wa    = idx_w;
    rec_wd    = cmd_r;
    link_we   = 1'b0;
    st_we     = 1'b0;
    st_wa     = idx_w;
    st_wd     = ST_EMPTY;
    res_ld    = 1'b0;
    res_code  = RC_NOTHING;
    res_idx   = '0;
    res_rec   = '0;

    unique case (seq_r)
      S_IDLE: begin
        if (accept) seq_nxt = S_DEC;
      end
      S_DEC: begin
        if (op_r == OP_REGISTER) begin
          if (head_full) begin
            res_ld   = 1'b1;
            res_code = RC_FULL;
            seq_nxt  = S_IDLE;
          end else begin
            rec_we  = 1'b1;
            rec_wa  = head_w;
            st_we   = 1'b1;
            st_wa   = head_w;
            st_wd   = ST_ACTIVE;
            seq_nxt = S_LINK;
          end
        end else if (op_r == OP_END_OP || op_r == OP_CHECK || op_r == OP_UNREG) begin
          if (idx_oob) begin
            res_ld   = 1'b1;
            res_code = RC_RANGE;
            res_idx  = idx_r;
            seq_nxt  = S_IDLE;
          end else begin
            seq_nxt = S_RMW;
          end
        end else if (op_r == OP_CLEAN) begin
          scan_nxt  = '0;
          found_nxt = 1'b0;
          seq_nxt   = S_SCAN;
        end else begin
          res_ld  = 1'b1;
          seq_nxt = S_IDLE;
        end
      end
      S_LINK: begin
        // head still in the untouched tail of the initial chain: next is head+1
        if (head_r == fill_r) begin
          head_nxt = fill_r + CW'(1);
          fill_nxt = fill_r + CW'(1);
        end else begin
          head_nxt = link_q;
        end
        res_ld   = 1'b1;
        res_code = RC_OK;
        res_idx  = IDX_W'(head_w);
        res_rec  = cmd_r;
        seq_nxt  = S_IDLE;
      end
      S_RMW: begin
        res_ld  = 1'b1;
        res_idx = idx_r;
        res_rec = cur_rec;
        seq_nxt = S_IDLE;
        if (op_r == OP_END_OP) begin
          if (cur_st != ST_ACTIVE) begin
            res_code = RC_NOT_READY;
          end else begin
            rec_wd            = rec_q;
            rec_wd.last_stamp = cmd_r.stamp;
            rec_wd.ops        = rec_q.ops + 32'd1;
            rec_we            = 1'b1;
            res_rec           = rec_wd;
            res_code          = RC_OK;
          end
        end else if ((op_r == OP_CHECK && cur_st == ST_STALE) ||
                     (op_r == OP_UNREG && cur_st != ST_EMPTY)) begin
          res_code = RC_OK;
          st_we    = 1'b1;
          st_wd    = ST_EMPTY;
          link_we  = 1'b1;
          head_nxt = CW'(idx_w);
        end else begin
          res_code = RC_NOTHING;
        end
      end
      S_SCAN: begin
        rd_addr = scan_r[IW-1:0];
        if (scan_r < n_r) begin
          cmp_v_nxt = 1'b1;
          scan_nxt  = scan_r + CW'(1);
        end
        if (cmp_v_r && (cur_st == ST_ACTIVE || cur_st == ST_SYNC) &&
            rec_q.address == cmd_r.address && rec_q.port == cmd_r.port) begin
          st_we     = 1'b1;
          st_wa     = cmp_idx_r;
          st_wd     = ST_STALE;
          found_nxt = 1'b1;
          last_nxt  = cmp_idx_r;
          thr_nxt   = rec_q.thread;
        end
        if (!cmp_v_r && scan_r >= n_r) begin
          res_ld   = 1'b1;
          res_code = found_r ? RC_OK : RC_NO_MATCH;
          res_idx  = found_r ? IDX_W'(last_r) : '0;
          res_rec.thread = found_r ? thr_r : 8'd0;
          seq_nxt  = S_IDLE;
        end
      end
      default: seq_nxt = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    rec_q    <= rec_mem[rd_addr];
    st_q     <= st_mem[rd_addr];
    rd_idx_r <= rd_addr;
    link_q   <= link_mem[head_w];
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (st_we) st_mem[st_wa] <= st_wd;
    if (link_we) link_mem[idx_w] <= head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= S_IDLE;
      n_r        <= CW'(MAX_ENTRIES);
      head_r     <= '0;
      fill_r     <= '0;
      out_strobe <= 1'b0;
      cmp_v_r    <= 1'b0;
    end else begin
      seq_r      <= seq_nxt;
      out_strobe <= res_ld;
      cmp_v_r    <= cmp_v_nxt;
      if (rebuild) begin
        n_r    <= cfg_clamped;
        head_r <= '0;
        fill_r <= '0;
      end else begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    cmp_idx_r <= scan_r[IW-1:0];
    found_r   <= found_nxt;
    last_r    <= last_nxt;
    thr_r     <= thr_nxt;
    if (accept) begin
      op_r             <= in_operation;
      idx_r            <= in_entry_index;
      cmd_r.thread     <= in_worker_thread;
      cmd_r.socket     <= in_socket_handle;
      cmd_r.address    <= in_peer_address;
      cmd_r.port       <= in_peer_port;
      cmd_r.stamp      <= in_now_seconds;
      cmd_r.last_stamp <= '0;
      cmd_r.ops        <= '0;
    end
    if (res_ld) begin
      out_result_code       <= res_code;
      out_result_index      <= res_idx;
      out_result_thread     <= res_rec.thread;
      out_result_socket     <= res_rec.socket;
      out_result_address    <= res_rec.address;
      out_result_port       <= res_rec.port;
      out_result_entry_time <= res_rec.stamp;
      out_result_last_time  <= res_rec.last_stamp;
      out_result_op_count   <= res_rec.ops;
    end
  end

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_r)
    else $error("fresh pointer beyond managed entries");

endmodule

>>> dv/ctfl_checker.sv
// ----------------------------------------------------------------------------
// ctfl_checker
// Watches the command, config and result channels of the connection table,
// keeps its own copy of the table and free list, and compares every result
// word field by field against the predicted one.
// ----------------------------------------------------------------------------
module ctfl_checker
  import ctfl_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [7:0]        in_worker_thread,
  input  logic [15:0]       in_socket_handle,
  input  logic [31:0]       in_peer_address,
  input  logic [15:0]       in_peer_port,
  input  logic [31:0]       in_now_seconds,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              out_strobe,
  input  logic [CODE_W-1:0] out_result_code,
  input  logic [IDX_W-1:0]  out_result_index,
  input  logic [7:0]        out_result_thread,
  input  logic [15:0]       out_result_socket,
  input  logic [31:0]       out_result_address,
  input  logic [15:0]       out_result_port,
  input  logic [31:0]       out_result_entry_time,
  input  logic [31:0]       out_result_last_time,
  input  logic [31:0]       out_result_op_count,
  output int                fail_count,
  output int                pending_count,
  output int                result_count
);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  index;
    entry_rec_t        rec;
  } table_word_t;

  localparam int unsigned LINK_NONE = MAX_ENTRIES;

  logic [1:0]  slot_state [MAX_ENTRIES];
  int unsigned slot_link [MAX_ENTRIES];
  entry_rec_t  slot_rec [MAX_ENTRIES];
  int unsigned free_head;
  int unsigned table_size;
  table_word_t expected_words[$];

  function automatic void rebuild_table();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_state[i] = ST_EMPTY;
      slot_rec[i] = '0;
      slot_link[i] = (i + 1 < table_size) ? i + 1 : LINK_NONE;
    end
    free_head = 0;
  endfunction

  function automatic table_word_t slot_word(logic [CODE_W-1:0] code, int unsigned idx);
    table_word_t w;
    w.code = code;
    w.index = idx[IDX_W-1:0];
    w.rec = slot_rec[idx];
    return w;
  endfunction

  function automatic void release_slot(int unsigned idx);
    slot_state[idx] = ST_EMPTY;
    slot_rec[idx] = '0;
    slot_link[idx] = free_head;
    free_head = idx;
  endfunction

  function automatic table_word_t predict_word();
    table_word_t w;
    int unsigned h;
    int unsigned idx;
    bit found;
    w = '0;
    idx = 32'(in_entry_index);
    case (in_operation)
      OP_REGISTER: begin
        h = free_head;
        if (h >= table_size) begin
          w.code = RC_FULL;
        end else begin
          free_head = slot_link[h];
          slot_link[h] = LINK_NONE;
          slot_state[h] = ST_ACTIVE;
          slot_rec[h].thread = in_worker_thread;
          slot_rec[h].socket = in_socket_handle;
          slot_rec[h].address = in_peer_address;
          slot_rec[h].port = in_peer_port;
          slot_rec[h].stamp = in_now_seconds;
          slot_rec[h].last_stamp = '0;
          slot_rec[h].ops = '0;
          w = slot_word(RC_OK, h);
        end
      end
      OP_END_OP, OP_CHECK, OP_UNREG: begin
        if (idx >= table_size) begin
          w.code = RC_RANGE;
          w.index = in_entry_index;
        end else if (in_operation == OP_END_OP) begin
          if (slot_state[idx] != ST_ACTIVE) begin
            w = slot_word(RC_NOT_READY, idx);
          end else begin
            slot_rec[idx].last_stamp = in_now_seconds;
            slot_rec[idx].ops = slot_rec[idx].ops + 32'd1;
            w = slot_word(RC_OK, idx);
          end
        end else if (in_operation == OP_CHECK) begin
          if (slot_state[idx] != ST_STALE) begin
            w = slot_word(RC_NOTHING, idx);
          end else begin
            w = slot_word(RC_OK, idx);
            release_slot(idx);
          end
        end else if (slot_state[idx] == ST_EMPTY) begin
          w = slot_word(RC_NOTHING, idx);
        end else begin
          w = slot_word(RC_OK, idx);
          release_slot(idx);
        end
      end
      OP_CLEAN: begin
        found = 0;
        for (int i = 0; i < table_size; i++) begin
          if ((slot_state[i] == ST_ACTIVE || slot_state[i] == ST_SYNC) &&
              slot_rec[i].address == in_peer_address && slot_rec[i].port == in_peer_port) begin
            slot_state[i] = ST_STALE;
            found = 1;
            w.index = i[IDX_W-1:0];
            w.rec.thread = slot_rec[i].thread;
          end
        end
        w.code = found ? RC_OK : RC_NO_MATCH;
      end
      default: w.code = RC_NOTHING;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, result_count);
    fail_count++;
  endtask

  always @(posedge clk) begin
    table_word_t w;
    int unsigned v;
    if (!rst_n) begin
      table_size = MAX_ENTRIES;
      rebuild_table();
      expected_words.delete();
      fail_count = 0;
      pending_count = 0;
      result_count <= 0;
    end else begin
      // result of the previous word may share the edge with the next start
      if (out_strobe) begin
        result_count <= result_count + 1;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_result_code), 64'(0));
        end else begin
          w = expected_words.pop_front();
          if (out_result_code !== w.code)
            report_mismatch("code", 64'(out_result_code), 64'(w.code));
          if (out_result_index !== w.index)
            report_mismatch("index", 64'(out_result_index), 64'(w.index));
          if (out_result_thread !== w.rec.thread)
            report_mismatch("thread", 64'(out_result_thread), 64'(w.rec.thread));
          if (out_result_socket !== w.rec.socket)
            report_mismatch("socket", 64'(out_result_socket), 64'(w.rec.socket));
          if (out_result_address !== w.rec.address)
            report_mismatch("address", 64'(out_result_address), 64'(w.rec.address));
          if (out_result_port !== w.rec.port)
            report_mismatch("port", 64'(out_result_port), 64'(w.rec.port));
          if (out_result_entry_time !== w.rec.stamp)
            report_mismatch("entry_time", 64'(out_result_entry_time), 64'(w.rec.stamp));
          if (out_result_last_time !== w.rec.last_stamp)
            report_mismatch("last_time", 64'(out_result_last_time),
                            64'(w.rec.last_stamp));
          if (out_result_op_count !== w.rec.ops)
            report_mismatch("op_count", 64'(out_result_op_count), 64'(w.rec.ops));
        end
      end
      if (cfg_valid && cfg_ready) begin
        v = 32'(cfg_data);
        if (v < 1) v = 1;
        if (v > MAX_ENTRIES) v = MAX_ENTRIES;
        table_size = v;
        rebuild_table();
      end
      if (start && !busy) expected_words.push_back(predict_word());
      pending_count = expected_words.size();
    end
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the connection table: directed corner words, then random
// phases of table sizes with realistic register/end/clean/free traffic.
// ----------------------------------------------------------------------------
module tb_top;
  import ctfl_pkg::*;

  localparam int unsigned MAXE = MAX_ENTRIES_DEF;
  localparam int WATCHDOG = 4000;

  logic clk, rst_n, start, busy, cfg_valid, cfg_ready, out_strobe;
  logic [OP_W-1:0] in_operation;
  logic [IDX_W-1:0] in_entry_index;
  logic [7:0] in_worker_thread;
  logic [15:0] in_socket_handle, in_peer_port;
  logic [31:0] in_peer_address, in_now_seconds;
  logic [CFG_W-1:0] cfg_data;
  logic [CODE_W-1:0] out_result_code;
  logic [IDX_W-1:0] out_result_index;
  logic [7:0] out_result_thread;
  logic [15:0] out_result_socket, out_result_port;
  logic [31:0] out_result_address, out_result_entry_time, out_result_last_time;
  logic [31:0] out_result_op_count;
  int fail_count, pending_count, result_count;
  int idle_cycles, word_count, size_now, idle_pct;
  logic [31:0] clock_now;
  logic [31:0] addr_pool [4];
  logic [15:0] port_pool [4];

  connection_table_free_list_top #(.MAX_ENTRIES(MAXE)) dut (.*);

  ctfl_checker #(.MAX_ENTRIES(MAXE)) u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Watchdog expired");
      $display("Mismatches found");
      $finish;
    end
  end

  // start stays high after the accept; the next word or an idle cycle drops it
  task automatic send_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [7:0] thr,
                           logic [15:0] sock, logic [31:0] addr, logic [15:0] port,
                           logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    in_operation <= op;
    in_entry_index <= idx;
    in_worker_thread <= thr;
    in_socket_handle <= sock;
    in_peer_address <= addr;
    in_peer_port <= port;
    in_now_seconds <= now;
    start <= 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    word_count++;
  endtask

  task automatic write_size(logic [CFG_W-1:0] value);
    start <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (MAXE + 8) @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    size_now = (value < 1) ? 1 : (value > MAXE) ? MAXE : int'(value);
  endtask

  task automatic random_word();
    int k;
    int sel;
    logic [IDX_W-1:0] idx;
    k = $urandom_range(3);
    clock_now = clock_now + $urandom_range(5);
    sel = $urandom_range(99);
    idx = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(size_now - 1));
    if (sel < 30)
      send_word(OP_REGISTER, IDX_W'($urandom), 8'($urandom), 16'($urandom), addr_pool[k],
                port_pool[k], ($urandom_range(19) == 0) ? $urandom : clock_now);
    else if (sel < 55) send_word(OP_END_OP, idx, 8'($urandom), 16'($urandom), $urandom,
                                 16'($urandom), clock_now);
    else if (sel < 68) send_word(OP_CHECK, idx, 8'($urandom), 16'($urandom), $urandom,
                                 16'($urandom), clock_now);
    else if (sel < 82) send_word(OP_UNREG, idx, 8'($urandom), 16'($urandom), $urandom,
                                 16'($urandom), clock_now);
    else if (sel < 96)
      send_word(OP_CLEAN, IDX_W'($urandom), 8'($urandom), 16'($urandom),
                ($urandom_range(7) == 0) ? $urandom : addr_pool[k],
                ($urandom_range(7) == 0) ? 16'($urandom) : port_pool[k], clock_now);
    else send_word(OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), IDX_W'($urandom),
                   8'($urandom), 16'($urandom), $urandom, 16'($urandom), $urandom);
  endtask

  initial begin
    rst_n = 0; start = 0; cfg_valid = 0; cfg_data = '0;
    in_operation = '0; in_entry_index = '0; in_worker_thread = '0;
    in_socket_handle = '0; in_peer_address = '0; in_peer_port = '0; in_now_seconds = '0;
    idle_cycles = 0; word_count = 0; size_now = MAXE; idle_pct = 0;
    clock_now = 32'd1000;
    for (int i = 0; i < 4; i++) begin
      addr_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end
    repeat (2) @(negedge clk);
    rst_n = 1;

    // directed: extremes, every operation, the corner cases
    send_word(OP_END_OP, 0, 0, 0, 0, 0, 0);                        // not ready, empty
    send_word(OP_UNREG, 0, 0, 0, 0, 0, 0);                         // unregister empty
    send_word(OP_REGISTER, '1, '1, '1, '1, '1, '1);
    send_word(OP_REGISTER, 0, 0, 0, 0, 0, 0);
    send_word(OP_END_OP, 0, 0, 0, 0, 0, '1);
    send_word(OP_CHECK, 0, 0, 0, 0, 0, 5);                         // not obsolete
    send_word(OP_END_OP, '1, 0, 0, 0, 0, 0);                       // out of range
    send_word(OP_CHECK, 10'd64, 0, 0, 0, 0, 0);
    send_word(OP_UNREG, 10'd63, 0, 0, 0, 0, 0);
    send_word(OP_CLEAN, 0, 0, 0, 32'h1234, 16'h55, 0);             // no match
    send_word(OP_CLEAN, 0, 0, 0, '1, '1, 0);                       // match entry 0
    send_word(OP_END_OP, 0, 0, 0, 0, 0, 7);                        // obsolete, not ready
    send_word(OP_CHECK, 0, 0, 0, 0, 0, 0);                         // frees it
    send_word(OP_UNREG, 1, 0, 0, 0, 0, 0);
    send_word(OP_UNUSED_LO, '1, '1, '1, '1, '1, '1);
    send_word(OP_UNUSED_HI, 0, 0, 0, 0, 0, 0);
    write_size(7'd1);
    send_word(OP_REGISTER, 0, 8'h5a, 16'h1, 32'h0a000001, 16'd80, 1);
    send_word(OP_REGISTER, 0, 8'h5b, 16'h2, 32'h0a000001, 16'd80, 2); // full
    send_word(OP_CLEAN, 0, 0, 0, 32'h0a000001, 16'd80, 3);           // last entry scanned
    send_word(OP_UNREG, 1, 0, 0, 0, 0, 0);
    write_size(7'd0);
    write_size(7'd127);
    write_size(7'd64);

    for (int phase = 0; phase < 12; phase++) begin
      idle_pct = (phase < 4) ? 13 : (phase < 8) ? 70 : 0;
      case (phase % 4)
        0: write_size(7'd2);
        1: write_size(CFG_W'($urandom_range(3, 16)));
        2: write_size(7'd64);
        default: write_size(CFG_W'($urandom));
      endcase
      for (int n = 0; n < 65; n++) random_word();
    end

    start <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (MAXE + 8) @(negedge clk);
    $display("Ran %0d command words, %0d results checked, table sizes 1 to %0d.",
             word_count, result_count, MAXE);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hdl/ctfl_pkg.sv
hdl/connection_table_free_list_top.sv
dv/ctfl_checker.sv
dv/tb_top.sv
